FILE: hdl/nfci_pkg.sv
package nfci_pkg;

  localparam int unsigned ADDR_BITS_DEF = 20;
  localparam int unsigned CMD_ADDR_W    = 11;
  localparam int unsigned OUT_DEPTH     = 3;
  localparam int unsigned OUT_PTR_W     = 2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [CMD_ADDR_W-1:0] UNLOCK_ADDR1 = 11'h555;
  localparam logic [CMD_ADDR_W-1:0] UNLOCK_ADDR2 = 11'h2AA;

  localparam logic [7:0] UNLOCK_DATA1   = 8'hAA;
  localparam logic [7:0] UNLOCK_DATA2   = 8'h55;
  localparam logic [7:0] CMD_RESET      = 8'hF0;
  localparam logic [7:0] CMD_AUTOSELECT = 8'h90;
  localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
  localparam logic [7:0] CMD_ERASE      = 8'h80;
  localparam logic [7:0] MAKER_CODE     = 8'h01;
  localparam logic [7:0] PART_CODE      = 8'hD5;
  localparam logic [7:0] ERASED_BYTE    = 8'h80;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;

  typedef enum logic [1:0] {
    MODE_ARRAY      = 2'd0,
    MODE_AUTOSEL    = 2'd1,
    MODE_PROGRAM    = 2'd2,
    MODE_ERASE_WAIT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_ONE  = 2'd1,
    STEP_TWO  = 2'd2
  } step_e;

  typedef enum logic [1:0] {
    ASEL_MAKER   = 2'd0,
    ASEL_PART    = 2'd1,
    ASEL_PROTECT = 2'd2,
    ASEL_NONE    = 2'd3
  } asel_e;

endpackage

FILE: hdl/nfci_ram.sv
module nfci_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/nor_flash_command_interface.sv
// Byte-wide NOR flash command interface.
// Input channel (in_valid_i/in_ready_o) carries one bus access per transaction:
// req_type_i selects read or write, byte_address_i and write_byte_i go with it.
// Every read gives exactly one transaction on the output channel
// (out_valid_o/out_ready_i, read_byte_o); writes give none.
// Writes drive the unlock sequence and the program command; a byte program
// ANDs the data into the array.
// A read's result is registered in stage one and then in the output queue
// before it is offered on out_valid_o.
// Throughput: one access per cycle while in_ready_o is high, set by the array
// memory, read at acceptance and written in the cycle after; a forwarding
// register covers a read of the byte programmed in the cycle before.
// A three-entry output queue lets accesses keep flowing while the receiver
// stalls; in_ready_o falls once queued and in-flight reads would fill it.
// After reset the array is cleared to 0x80 one byte a cycle, all 2**ADDR_BITS
// bytes (1,048,576 by default); in_ready_o stays low meanwhile.
// Configuration writes (cfg_we_i, cfg_wdata_i) are taken at any time.
module nor_flash_command_interface #(
  parameter int unsigned ADDR_BITS = nfci_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [ADDR_BITS-1:0] byte_address_i,
  input  logic [7:0]           write_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           read_byte_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);

  logic [7:0] protect_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protect_mask_q <= '0;
    end else if (cfg_we_i) begin
      protect_mask_q <= cfg_wdata_i;
    end
  end

  // Clearing pass.
  logic                 clearing_q;
  logic [ADDR_BITS-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Unlock detector and mode.
  nfci_pkg::step_e step_q, step_d;
  nfci_pkg::mode_e mode_q, mode_d;
  logic [nfci_pkg::CMD_ADDR_W-1:0] cmd_addr;

  assign cmd_addr = byte_address_i[nfci_pkg::CMD_ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= nfci_pkg::STEP_IDLE;
      mode_q <= nfci_pkg::MODE_ARRAY;
    end else begin
      step_q <= step_d;
      mode_q <= mode_d;
    end
  end

  always_comb begin
    step_d = step_q;
    mode_d = mode_q;
    if (in_acc && req_type_i) begin
      case (step_q)
        nfci_pkg::STEP_ONE: begin
          if (cmd_addr == nfci_pkg::UNLOCK_ADDR2 && write_byte_i == nfci_pkg::UNLOCK_DATA2) begin
            step_d = nfci_pkg::STEP_TWO;
            mode_d = nfci_pkg::MODE_AUTOSEL;
          end else begin
            step_d = nfci_pkg::STEP_IDLE;
          end
        end
        nfci_pkg::STEP_TWO: begin
          step_d = nfci_pkg::STEP_IDLE;
          if (cmd_addr == nfci_pkg::UNLOCK_ADDR1) begin
            case (write_byte_i)
              nfci_pkg::CMD_RESET:      mode_d = nfci_pkg::MODE_ARRAY;
              nfci_pkg::CMD_AUTOSELECT: mode_d = nfci_pkg::MODE_AUTOSEL;
              nfci_pkg::CMD_PROGRAM:    mode_d = nfci_pkg::MODE_PROGRAM;
              nfci_pkg::CMD_ERASE:      mode_d = nfci_pkg::MODE_ERASE_WAIT;
              default:                  mode_d = mode_q;
            endcase
          end
        end
        default: begin
          if (cmd_addr == nfci_pkg::UNLOCK_ADDR1 && write_byte_i == nfci_pkg::UNLOCK_DATA1) begin
            step_d = nfci_pkg::STEP_ONE;
          end else begin
            step_d = nfci_pkg::STEP_IDLE;
          end
        end
      endcase
      // The write after a program command programs and ends program mode.
      if (mode_q == nfci_pkg::MODE_PROGRAM) begin
        mode_d = nfci_pkg::MODE_ARRAY;
      end
    end
  end

  // Stage one: the array byte arrives from the memory.
  logic                 s1_valid_q;
  logic                 s1_write_q;
  logic                 s1_prog_q;
  nfci_pkg::mode_e      s1_mode_q;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic [7:0]           s1_data_q;
  logic                 s1_prot_q;
  logic [2:0]           group;

  assign group = byte_address_i[ADDR_BITS-1 -: 3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_prog_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_prog_q  <= in_acc && req_type_i && (mode_q == nfci_pkg::MODE_PROGRAM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_write_q <= req_type_i;
      s1_mode_q  <= mode_q;
      s1_addr_q  <= byte_address_i;
      s1_data_q  <= write_byte_i;
      s1_prot_q  <= protect_mask_q[group];
    end
  end

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;
  logic [7:0]           array_byte;
  logic                 s1_prog_wr;

  logic                 fwd_valid_q;
  logic [ADDR_BITS-1:0] fwd_addr_q;
  logic [7:0]           fwd_data_q;

  assign s1_prog_wr = s1_valid_q && s1_prog_q;
  // A byte written last cycle is not yet visible on the read port.
  assign array_byte = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;

  assign ram_we    = clearing_q || s1_prog_wr;
  assign ram_waddr = clearing_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clearing_q ? nfci_pkg::ERASED_BYTE : (array_byte & s1_data_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_prog_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_prog_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= ram_wdata;
    end
  end

  nfci_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_BITS)
  ) u_array (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (byte_address_i),
    .rdata_o (ram_rdata)
  );

  logic [7:0] rd_result;

  always_comb begin
    case (s1_mode_q)
      nfci_pkg::MODE_ARRAY: rd_result = array_byte;
      nfci_pkg::MODE_AUTOSEL: begin
        case (nfci_pkg::asel_e'(s1_addr_q[1:0]))
          nfci_pkg::ASEL_MAKER:   rd_result = nfci_pkg::MAKER_CODE;
          nfci_pkg::ASEL_PART:    rd_result = nfci_pkg::PART_CODE;
          nfci_pkg::ASEL_PROTECT: rd_result = {7'd0, s1_prot_q};
          default:                rd_result = nfci_pkg::IDLE_BYTE;
        endcase
      end
      default: rd_result = nfci_pkg::IDLE_BYTE;
    endcase
  end

  // Output queue.
  logic [7:0]                   fifo_q [nfci_pkg::OUT_DEPTH];
  logic [nfci_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q, cnt_q;
  logic                         push, pop;
  logic                         s1_read;
  logic [nfci_pkg::OUT_PTR_W:0] pending;

  assign s1_read = s1_valid_q && !s1_write_q;
  assign push    = s1_read;
  assign pop     = out_valid_o && out_ready_i;
  assign pending = {1'b0, cnt_q} + {{nfci_pkg::OUT_PTR_W{1'b0}}, s1_read};

  assign in_ready_o  = !clearing_q &&
                       (pending <= (nfci_pkg::OUT_PTR_W+1)'(nfci_pkg::OUT_DEPTH - 1));
  assign out_valid_o = (cnt_q != '0);
  assign read_byte_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == nfci_pkg::OUT_PTR_W'(nfci_pkg::OUT_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == nfci_pkg::OUT_PTR_W'(nfci_pkg::OUT_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= rd_result;
    end
  end

`ifndef SYNTH
  // Two program writes can never be in consecutive cycles: the unlock sequence lies between.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_prog_wr |=> !s1_prog_wr)
    else $error("back-to-back program writes");

  // No access is taken while the array is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !in_ready_o)
    else $error("access accepted during clearing pass");

  // The output queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == nfci_pkg::OUT_PTR_W'(nfci_pkg::OUT_DEPTH)) |-> !push || pop)
    else $error("output queue overflow");

  // A program write lands in read-array mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && req_type_i && mode_q == nfci_pkg::MODE_PROGRAM)
                   |=> (mode_q == nfci_pkg::MODE_ARRAY))
    else $error("program mode not left after program write");
`endif

endmodule

FILE: sim/nfci_access_checker.sv
module nfci_access_checker #(
  parameter int unsigned ADDR_BITS = nfci_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 req_type_i,
  input  logic [ADDR_BITS-1:0] byte_address_i,
  input  logic [7:0]           write_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           read_byte_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_reads_o
);
  timeunit 1ns;
  timeprecision 1ps;

  nfci_pkg::mode_e mode;
  nfci_pkg::step_e step;
  logic [7:0]      protect_mask;
  logic [7:0]      programmed [logic [ADDR_BITS-1:0]];
  logic [7:0]      read_bytes_due [$];
  logic [7:0]      due;
  int              fails;

  // Bytes that were never programmed still hold the erased value.
  function automatic logic [7:0] array_byte(input logic [ADDR_BITS-1:0] addr);
    if (programmed.exists(addr)) begin
      return programmed[addr];
    end
    return nfci_pkg::ERASED_BYTE;
  endfunction

  function automatic logic [7:0] predict_read(input logic [ADDR_BITS-1:0] addr);
    case (mode)
      nfci_pkg::MODE_ARRAY: begin
        return array_byte(addr);
      end
      nfci_pkg::MODE_AUTOSEL: begin
        case (nfci_pkg::asel_e'(addr[1:0]))
          nfci_pkg::ASEL_MAKER:   return nfci_pkg::MAKER_CODE;
          nfci_pkg::ASEL_PART:    return nfci_pkg::PART_CODE;
          nfci_pkg::ASEL_PROTECT: return {7'd0, protect_mask[addr[ADDR_BITS-1 -: 3]]};
          default:                return nfci_pkg::IDLE_BYTE;
        endcase
      end
      default: begin
        return nfci_pkg::IDLE_BYTE;
      end
    endcase
  endfunction

  task automatic apply_write(input logic [ADDR_BITS-1:0] addr, input logic [7:0] data);
    logic [nfci_pkg::CMD_ADDR_W-1:0] low;
    nfci_pkg::mode_e                 prior;
    low   = addr[nfci_pkg::CMD_ADDR_W-1:0];
    prior = mode;
    case (step)
      nfci_pkg::STEP_ONE: begin
        // The second unlock write already switches to autoselect.
        if (low == nfci_pkg::UNLOCK_ADDR2 && data == nfci_pkg::UNLOCK_DATA2) begin
          step = nfci_pkg::STEP_TWO;
          mode = nfci_pkg::MODE_AUTOSEL;
        end else begin
          step = nfci_pkg::STEP_IDLE;
        end
      end
      nfci_pkg::STEP_TWO: begin
        step = nfci_pkg::STEP_IDLE;
        if (low == nfci_pkg::UNLOCK_ADDR1) begin
          case (data)
            nfci_pkg::CMD_RESET:      mode = nfci_pkg::MODE_ARRAY;
            nfci_pkg::CMD_AUTOSELECT: mode = nfci_pkg::MODE_AUTOSEL;
            nfci_pkg::CMD_PROGRAM:    mode = nfci_pkg::MODE_PROGRAM;
            nfci_pkg::CMD_ERASE:      mode = nfci_pkg::MODE_ERASE_WAIT;
            default:                  ;
          endcase
        end
      end
      default: begin
        if (low == nfci_pkg::UNLOCK_ADDR1 && data == nfci_pkg::UNLOCK_DATA1) begin
          step = nfci_pkg::STEP_ONE;
        end else begin
          step = nfci_pkg::STEP_IDLE;
        end
      end
    endcase
    // The write after a program command programs, whatever the unlock logic made of it.
    if (prior == nfci_pkg::MODE_PROGRAM) begin
      programmed[addr] = array_byte(addr) & data;
      mode = nfci_pkg::MODE_ARRAY;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode         = nfci_pkg::MODE_ARRAY;
      step         = nfci_pkg::STEP_IDLE;
      protect_mask = '0;
      fails        = 0;
      programmed.delete();
      read_bytes_due.delete();
      fail_count_o    <= 0;
      pending_reads_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (read_bytes_due.size() == 0) begin
          $error("read_byte: no read outstanding, actual 0x%02h", read_byte_i);
          fails++;
        end else begin
          due = read_bytes_due.pop_front();
          if (read_byte_i !== due) begin
            $error("read_byte: expected 0x%02h, actual 0x%02h", due, read_byte_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == nfci_pkg::REQ_WRITE) begin
          apply_write(byte_address_i, write_byte_i);
        end else begin
          read_bytes_due.push_back(predict_read(byte_address_i));
        end
      end
      if (cfg_we_i) begin
        protect_mask = cfg_wdata_i;
      end
      fail_count_o    <= fails;
      pending_reads_o <= read_bytes_due.size();
    end
  end

endmodule

FILE: sim/nor_flash_command_interface_test.sv
module nor_flash_command_interface_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW          = nfci_pkg::ADDR_BITS_DEF;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 222;
  // The array is cleared byte by byte after reset before any access is taken.
  localparam int unsigned CYCLE_LIMIT = 2 * (1 << AW) + 500000;

  logic          clk          = 1'b0;
  logic          rst_n        = 1'b0;
  logic          in_valid     = 1'b0;
  logic          in_ready;
  logic          req_type     = nfci_pkg::REQ_READ;
  logic [AW-1:0] byte_address = '0;
  logic [7:0]    write_byte   = '0;
  logic          out_valid;
  logic          out_ready    = 1'b1;
  logic [7:0]    read_byte;
  logic          cfg_we       = 1'b0;
  logic [7:0]    cfg_wdata    = '0;

  int            fail_count;
  int            pending_reads;
  int unsigned   sent           = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  logic [AW-1:0] hot_addr [8];

  always #4 clk = ~clk;

  nor_flash_command_interface #(
    .ADDR_BITS(AW)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .byte_address_i(byte_address),
    .write_byte_i  (write_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_byte_o   (read_byte),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  nfci_access_checker #(
    .ADDR_BITS(AW)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .byte_address_i (byte_address),
    .write_byte_i   (write_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_byte_i    (read_byte),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_reads_o(pending_reads)
  );

  // Random address whose low bits hit a command address.
  function automatic logic [AW-1:0] cmd_addr(input logic [nfci_pkg::CMD_ADDR_W-1:0] low);
    logic [AW-1:0] addr;
    addr = AW'($urandom);
    addr[nfci_pkg::CMD_ADDR_W-1:0] = low;
    return addr;
  endfunction

  function automatic logic [AW-1:0] pick_addr();
    logic [AW-1:0] addr;
    case ($urandom_range(4))
      0, 1:    addr = hot_addr[3'($urandom_range(7))];
      2:       addr = cmd_addr($urandom_range(1) ? nfci_pkg::UNLOCK_ADDR1 :
                                                   nfci_pkg::UNLOCK_ADDR2);
      default: addr = AW'($urandom);
    endcase
    return addr;
  endfunction

  task automatic bus_access(input logic kind, input logic [AW-1:0] addr,
                            input logic [7:0] data);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    byte_address <= addr;
    write_byte   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic unlock_cmd(input logic [7:0] cmd);
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR1), nfci_pkg::UNLOCK_DATA1);
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR2), nfci_pkg::UNLOCK_DATA2);
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR1), cmd);
  endtask

  // Stops sending and waits for every read result, then gives a program write
  // still in flight time to land.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mask(input logic [7:0] mask);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned target);
    logic [AW-1:0] addr;
    logic [7:0]    cmd;
    while (sent < target) begin
      addr = pick_addr();
      case ($urandom_range(9))
        0, 1, 2: begin
          case ($urandom_range(5))
            0:       cmd = nfci_pkg::CMD_RESET;
            1:       cmd = nfci_pkg::CMD_AUTOSELECT;
            2, 3:    cmd = nfci_pkg::CMD_PROGRAM;
            4:       cmd = nfci_pkg::CMD_ERASE;
            default: cmd = 8'($urandom);
          endcase
          unlock_cmd(cmd);
          if (cmd == nfci_pkg::CMD_PROGRAM && $urandom_range(3) != 0) begin
            bus_access(nfci_pkg::REQ_WRITE, addr, 8'($urandom));
            // A read straight after the program exercises the forwarding path.
            if ($urandom_range(1)) begin
              bus_access(nfci_pkg::REQ_READ, addr, 8'($urandom));
            end
          end
        end
        3: begin
          bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR1),
                     nfci_pkg::UNLOCK_DATA1);
          if ($urandom_range(1)) begin
            bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR2), 8'($urandom));
          end else begin
            bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR2),
                       nfci_pkg::UNLOCK_DATA2);
            bus_access(nfci_pkg::REQ_WRITE, addr, 8'($urandom));
          end
        end
        4: begin
          bus_access(nfci_pkg::REQ_WRITE, addr, 8'($urandom));
        end
        default: begin
          bus_access(nfci_pkg::REQ_READ, addr, 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    logic [7:0]  mask;
    for (int i = 0; i < 8; i++) begin
      hot_addr[i] = AW'($urandom);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mask(8'hFF);

    // Directed accesses: erased reads at both address extremes, autoselect
    // codes, a byte program, erase wait, and the broken unlock sequences.
    bus_access(nfci_pkg::REQ_READ,  20'h00000, 8'h00);
    bus_access(nfci_pkg::REQ_READ,  20'hFFFFF, 8'hFF);
    bus_access(nfci_pkg::REQ_WRITE, 20'h00555, nfci_pkg::UNLOCK_DATA1);
    bus_access(nfci_pkg::REQ_WRITE, 20'hFF2AA, nfci_pkg::UNLOCK_DATA2);
    bus_access(nfci_pkg::REQ_READ,  20'h00000, 8'h00);
    bus_access(nfci_pkg::REQ_READ,  20'hFFFFD, 8'h00);
    bus_access(nfci_pkg::REQ_READ,  20'hE0002, 8'h00);
    bus_access(nfci_pkg::REQ_READ,  20'h00003, 8'h00);
    unlock_cmd(nfci_pkg::CMD_PROGRAM);
    bus_access(nfci_pkg::REQ_WRITE, 20'h12345, 8'h7F);
    bus_access(nfci_pkg::REQ_READ,  20'h12345, 8'h00);
    unlock_cmd(nfci_pkg::CMD_ERASE);
    bus_access(nfci_pkg::REQ_READ,  20'h12345, 8'h00);
    bus_access(nfci_pkg::REQ_WRITE, 20'h00000, 8'h00);
    // An unknown command leaves the part in autoselect.
    unlock_cmd(8'h33);
    bus_access(nfci_pkg::REQ_READ,  20'h00001, 8'h00);
    // A third step at the wrong address is dropped as well.
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR1), nfci_pkg::UNLOCK_DATA1);
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR2), nfci_pkg::UNLOCK_DATA2);
    bus_access(nfci_pkg::REQ_WRITE, cmd_addr(nfci_pkg::UNLOCK_ADDR2), nfci_pkg::CMD_RESET);
    unlock_cmd(nfci_pkg::CMD_RESET);
    bus_access(nfci_pkg::REQ_READ,  20'h00000, 8'h00);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0:       mask = 8'h00;
        2:       mask = 8'hFF;
        4:       mask = 8'h5A;
        default: mask = 8'($urandom);
      endcase
      set_mask(mask);
      case (phase)
        1:       begin send_idle_pct = 20; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 30; end
        3:       begin send_idle_pct = 15; recv_stall_pct = 15; end
        4:       begin send_idle_pct = 40; recv_stall_pct = 40; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      random_traffic(sent + PHASE_ITEMS);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
